// File: rtl/rhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the rgb to hsv converter
// Holds the pixel and result word types, the hue sector codes and the
// fixed-point constants of the hue and saturation datapath.
// ----------------------------------------------------------------------------
package rhc_pkg;

   // default width of one colour channel inside the datapath
   localparam int CHANNEL_BITS = 8;

   // width of each field of the incoming pixel word
   localparam int PIXEL_BITS = 8;

   // result field widths
   localparam int HUE_BITS        = 15;
   localparam int SAT_BITS        = 8;
   localparam int BRIGHTNESS_BITS = 8;

   // hue in 1/64 degree: one sector of 60 degrees, and the full circle
   localparam int HUE_SECTOR = 3840;
   localparam int HUE_FULL   = 23040;

   // saturation scale, 255 means 1.0
   localparam int SAT_SCALE = 255;

   // sector base offsets for green and blue maxima
   localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = HUE_BITS'(2 * HUE_SECTOR);
   localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE  = HUE_BITS'(4 * HUE_SECTOR);
   localparam logic [HUE_BITS-1:0] HUE_WRAP       = HUE_BITS'(HUE_FULL);

   // divider: quotient bits (hue quotient reaches 3840) and bits per stage
   localparam int QUOT_BITS  = 12;
   localparam int STEP_BITS  = 2;
   localparam int DIV_STAGES = QUOT_BITS / STEP_BITS;

   // register stages ahead of the dividers
   localparam int FRONT_STAGES = 3;

   // which channel holds the maximum, ties go red, then green, then blue
   typedef enum logic [2:0] {
      SECTOR_RED   = 3'b001,
      SECTOR_GREEN = 3'b010,
      SECTOR_BLUE  = 3'b100
   } sector_type;

   // incoming pixel word
   typedef struct packed {
      logic [PIXEL_BITS-1:0] red;
      logic [PIXEL_BITS-1:0] green;
      logic [PIXEL_BITS-1:0] blue;
   } pixel_type;

   // outgoing result word
   typedef struct packed {
      logic [HUE_BITS-1:0]        hue;
      logic [SAT_BITS-1:0]        saturation;
      logic [BRIGHTNESS_BITS-1:0] brightness;
   } hsv_type;

   // per-pixel control carried alongside the dividers
   typedef struct packed {
      sector_type                 sector;
      logic                       negative;
      logic                       grey;
      logic                       black;
      logic [BRIGHTNESS_BITS-1:0] brightness;
   } side_type;

endpackage
`default_nettype wire

// File: rtl/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// a taken word passes 3 front stages, 6 divider stages at 2 quotient bits
// each and 1 output stage before its result leaves
// throughput: one word per cycle; busy stays low, so start may be held high
// reset clears only the valid bits; words in flight at reset are dropped
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: pipelined rgb to hsv colour conversion
// Brightness is the largest channel, saturation is chroma over max scaled
// to 255, hue follows the six-sector formula in 1/64 degree units.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
   parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  rhc_pkg::pixel_type req_data,
   output logic               rsp_strobe,
   output rhc_pkg::hsv_type   rsp_data
);

   localparam int DIVIDEND_BITS = CHANNEL_BITS + rhc_pkg::QUOT_BITS;
   localparam int LATENCY       = rhc_pkg::FRONT_STAGES + rhc_pkg::DIV_STAGES + 1;

   logic                        front_valid;
   rhc_pkg::side_type           front_side;
   logic [DIVIDEND_BITS-1:0]    hue_num;
   logic [CHANNEL_BITS-1:0]     hue_den;
   logic [DIVIDEND_BITS-1:0]    sat_num;
   logic [CHANNEL_BITS-1:0]     sat_den;
   logic [rhc_pkg::QUOT_BITS-1:0] hue_quo;
   logic [rhc_pkg::QUOT_BITS-1:0] sat_quo;
   logic                        hue_rem_nz;
   logic                        sat_rem_nz;

   logic                        valid_ff [rhc_pkg::DIV_STAGES];
   rhc_pkg::side_type           side_ff  [rhc_pkg::DIV_STAGES];

   logic                        rsp_strobe_ff;
   rhc_pkg::hsv_type            rsp_data_ff;
   rhc_pkg::hsv_type            rsp_data_in;

   // never stalls
   assign busy = 1'b0;

   rhc_front #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_pixel  (req_data),
      .out_valid (front_valid),
      .out_side  (front_side),
      .hue_num   (hue_num),
      .hue_den   (hue_den),
      .sat_num   (sat_num),
      .sat_den   (sat_den)
   );

   // hue quotient: 3840 * |difference| / chroma
   rhc_div #(
      .DIVIDEND_BITS (DIVIDEND_BITS),
      .DIVISOR_BITS  (CHANNEL_BITS),
      .QUOT_BITS     (rhc_pkg::QUOT_BITS),
      .STEP_BITS     (rhc_pkg::STEP_BITS)
   ) u_hue_div (
      .clock       (clock),
      .dividend    (hue_num),
      .divisor     (hue_den),
      .quotient    (hue_quo),
      .rem_nonzero (hue_rem_nz)
   );

   // saturation quotient: 255 * chroma / max, remainder unused
   rhc_div #(
      .DIVIDEND_BITS (DIVIDEND_BITS),
      .DIVISOR_BITS  (CHANNEL_BITS),
      .QUOT_BITS     (rhc_pkg::QUOT_BITS),
      .STEP_BITS     (rhc_pkg::STEP_BITS)
   ) u_sat_div (
      .clock       (clock),
      .dividend    (sat_num),
      .divisor     (sat_den),
      .quotient    (sat_quo),
      .rem_nonzero (sat_rem_nz)
   );

   // control fields travel beside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rhc_pkg::DIV_STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= front_valid;
         for (int i = 1; i < rhc_pkg::DIV_STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
      side_ff[0] <= front_side;
      for (int i = 1; i < rhc_pkg::DIV_STAGES; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // hue assembly: sector base plus the floored signed quotient
   always_comb begin
      rhc_pkg::side_type             side;
      logic [rhc_pkg::HUE_BITS-1:0]  base;
      logic [rhc_pkg::HUE_BITS-1:0]  quo;
      logic [rhc_pkg::HUE_BITS-1:0]  up;
      side = side_ff[rhc_pkg::DIV_STAGES-1];
      quo  = rhc_pkg::HUE_BITS'(hue_quo);
      up   = rhc_pkg::HUE_BITS'(hue_rem_nz);
      case (side.sector)
         rhc_pkg::SECTOR_RED:   base = side.negative ? rhc_pkg::HUE_WRAP : '0;
         rhc_pkg::SECTOR_GREEN: base = rhc_pkg::HUE_GREEN_BASE;
         rhc_pkg::SECTOR_BLUE:  base = rhc_pkg::HUE_BLUE_BASE;
         default:               base = '0;
      endcase
      if (side.grey) begin
         rsp_data_in.hue = '0;
      end else if (side.negative) begin
         rsp_data_in.hue = base - quo - up;
      end else begin
         rsp_data_in.hue = base + quo;
      end
      rsp_data_in.saturation = side.black ? '0 : rhc_pkg::SAT_BITS'(sat_quo);
      rsp_data_in.brightness = side.brightness;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_ff[rhc_pkg::DIV_STAGES-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every result word goes back to a word taken a fixed latency earlier
   a_strobe_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result word without a matching request word");

   // hue quotient never exceeds one sector
   a_hue_quo_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[rhc_pkg::DIV_STAGES-1] && !side_ff[rhc_pkg::DIV_STAGES-1].grey)
      |-> (hue_quo <= rhc_pkg::QUOT_BITS'(rhc_pkg::HUE_SECTOR)))
      else $error("hue quotient beyond one sector");

   // saturation quotient stays within the scale
   a_sat_quo_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[rhc_pkg::DIV_STAGES-1] && !side_ff[rhc_pkg::DIV_STAGES-1].black)
      |-> (sat_quo <= rhc_pkg::QUOT_BITS'(rhc_pkg::SAT_SCALE)))
      else $error("saturation quotient beyond full scale");

   // hue always lands below a full circle
   a_hue_below_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.hue < rhc_pkg::HUE_WRAP))
      else $error("hue at or above 360 degrees");

   // the saturation divider remainder is not needed; keep it observed
   // black divides by zero, so only a lit grey is checked
   a_sat_rem_known: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[rhc_pkg::DIV_STAGES-1] && side_ff[rhc_pkg::DIV_STAGES-1].grey
       && !side_ff[rhc_pkg::DIV_STAGES-1].black)
      |-> (sat_quo == '0 && !sat_rem_nz))
      else $error("grey pixel with nonzero saturation quotient");

endmodule
`default_nettype wire

// File: rtl/rhc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_front: front end of the rgb to hsv pipeline
// Three register stages: input capture, max/min/chroma and sector selection,
// then scaling of the hue and saturation dividends.
// ----------------------------------------------------------------------------
module rhc_front #(
   parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS,
   localparam int DIVIDEND_BITS = CHANNEL_BITS + rhc_pkg::QUOT_BITS
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   input  rhc_pkg::pixel_type           in_pixel,
   output logic                         out_valid,
   output rhc_pkg::side_type            out_side,
   output logic [DIVIDEND_BITS-1:0]     hue_num,
   output logic [CHANNEL_BITS-1:0]      hue_den,
   output logic [DIVIDEND_BITS-1:0]     sat_num,
   output logic [CHANNEL_BITS-1:0]      sat_den
);

   // stage a registers
   logic                    valid_a_ff;
   logic [CHANNEL_BITS-1:0] red_a_ff;
   logic [CHANNEL_BITS-1:0] green_a_ff;
   logic [CHANNEL_BITS-1:0] blue_a_ff;

   // stage b registers
   logic                    valid_b_ff;
   logic [CHANNEL_BITS-1:0] max_b_ff;
   logic [CHANNEL_BITS-1:0] max_b_in;
   logic [CHANNEL_BITS-1:0] chroma_b_ff;
   logic [CHANNEL_BITS-1:0] chroma_b_in;
   logic [CHANNEL_BITS-1:0] mag_b_ff;
   logic [CHANNEL_BITS-1:0] mag_b_in;
   logic                    neg_b_ff;
   logic                    neg_b_in;
   rhc_pkg::sector_type     sector_b_ff;
   rhc_pkg::sector_type     sector_b_in;

   // stage c registers
   logic                     valid_c_ff;
   rhc_pkg::side_type        side_c_ff;
   rhc_pkg::side_type        side_c_in;
   logic [DIVIDEND_BITS-1:0] hue_num_ff;
   logic [DIVIDEND_BITS-1:0] hue_num_in;
   logic [DIVIDEND_BITS-1:0] sat_num_ff;
   logic [DIVIDEND_BITS-1:0] sat_num_in;
   logic [CHANNEL_BITS-1:0]  hue_den_ff;
   logic [CHANNEL_BITS-1:0]  sat_den_ff;

   // capture the pixel word, fitted to the channel width
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      red_a_ff   <= CHANNEL_BITS'(in_pixel.red);
      green_a_ff <= CHANNEL_BITS'(in_pixel.green);
      blue_a_ff  <= CHANNEL_BITS'(in_pixel.blue);
   end

   // max, min, chroma and the signed difference of the sector
   always_comb begin
      logic                    r_ge_g;
      logic                    r_ge_b;
      logic                    g_ge_b;
      logic [CHANNEL_BITS-1:0] min_val;
      logic [CHANNEL_BITS-1:0] op_a;
      logic [CHANNEL_BITS-1:0] op_b;
      r_ge_g = red_a_ff >= green_a_ff;
      r_ge_b = red_a_ff >= blue_a_ff;
      g_ge_b = green_a_ff >= blue_a_ff;
      if (r_ge_g && r_ge_b) begin
         sector_b_in = rhc_pkg::SECTOR_RED;
         max_b_in    = red_a_ff;
         op_a        = green_a_ff;
         op_b        = blue_a_ff;
      end else if (g_ge_b) begin
         sector_b_in = rhc_pkg::SECTOR_GREEN;
         max_b_in    = green_a_ff;
         op_a        = blue_a_ff;
         op_b        = red_a_ff;
      end else begin
         sector_b_in = rhc_pkg::SECTOR_BLUE;
         max_b_in    = blue_a_ff;
         op_a        = red_a_ff;
         op_b        = green_a_ff;
      end
      if (!r_ge_g && !r_ge_b) begin
         min_val = red_a_ff;
      end else if (g_ge_b) begin
         min_val = blue_a_ff;
      end else begin
         min_val = green_a_ff;
      end
      if (red_a_ff <= green_a_ff && red_a_ff <= blue_a_ff) begin
         min_val = red_a_ff;
      end
      chroma_b_in = max_b_in - min_val;
      neg_b_in    = op_a < op_b;
      mag_b_in    = neg_b_in ? (op_b - op_a) : (op_a - op_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      max_b_ff    <= max_b_in;
      chroma_b_ff <= chroma_b_in;
      mag_b_ff    <= mag_b_in;
      neg_b_ff    <= neg_b_in;
      sector_b_ff <= sector_b_in;
   end

   // scale the dividends by constants and collect the control fields
   always_comb begin
      hue_num_in = DIVIDEND_BITS'(mag_b_ff) * DIVIDEND_BITS'(rhc_pkg::HUE_SECTOR);
      sat_num_in = DIVIDEND_BITS'(chroma_b_ff) * DIVIDEND_BITS'(rhc_pkg::SAT_SCALE);
      side_c_in.sector     = sector_b_ff;
      side_c_in.negative   = neg_b_ff;
      side_c_in.grey       = chroma_b_ff == '0;
      side_c_in.black      = max_b_ff == '0;
      side_c_in.brightness = rhc_pkg::BRIGHTNESS_BITS'(max_b_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else begin
         valid_c_ff <= valid_b_ff;
      end
      side_c_ff  <= side_c_in;
      hue_num_ff <= hue_num_in;
      sat_num_ff <= sat_num_in;
      hue_den_ff <= chroma_b_ff;
      sat_den_ff <= max_b_ff;
   end

   assign out_valid = valid_c_ff;
   assign out_side  = side_c_ff;
   assign hue_num   = hue_num_ff;
   assign hue_den   = hue_den_ff;
   assign sat_num   = sat_num_ff;
   assign sat_den   = sat_den_ff;

endmodule
`default_nettype wire

// File: rtl/rhc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_div: pipelined restoring divider
// Produces a few quotient bits per register stage, one new division per
// cycle. The dividend must be below divisor times two to the quotient width.
// ----------------------------------------------------------------------------
module rhc_div #(
   parameter int DIVIDEND_BITS = rhc_pkg::CHANNEL_BITS + rhc_pkg::QUOT_BITS,
   parameter int DIVISOR_BITS  = rhc_pkg::CHANNEL_BITS,
   parameter int QUOT_BITS     = rhc_pkg::QUOT_BITS,
   parameter int STEP_BITS     = rhc_pkg::STEP_BITS,
   localparam int STAGES       = QUOT_BITS / STEP_BITS
) (
   input  wire                       clock,
   input  wire  [DIVIDEND_BITS-1:0]  dividend,
   input  wire  [DIVISOR_BITS-1:0]   divisor,
   output logic [QUOT_BITS-1:0]      quotient,
   output logic                      rem_nonzero
);

   logic [DIVIDEND_BITS-1:0] rem_ff [STAGES];
   logic [DIVISOR_BITS-1:0]  den_ff [STAGES];
   logic [QUOT_BITS-1:0]     quo_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [DIVIDEND_BITS-1:0] rem_src;
      logic [DIVISOR_BITS-1:0]  den_src;
      logic [QUOT_BITS-1:0]     quo_src;
      logic [DIVIDEND_BITS-1:0] rem_in;
      logic [QUOT_BITS-1:0]     quo_in;

      // stage source: the inputs, or the previous stage
      if (s == 0) begin : g_first
         assign rem_src = dividend;
         assign den_src = divisor;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      // trial subtract for each quotient bit of this stage, msb first
      always_comb begin
         logic [DIVIDEND_BITS-1:0] rem;
         logic [QUOT_BITS-1:0]     quo;
         logic [DIVIDEND_BITS-1:0] trial;
         rem = rem_src;
         quo = quo_src;
         for (int k = 0; k < STEP_BITS; k++) begin
            trial = DIVIDEND_BITS'(den_src) << (QUOT_BITS - 1 - s * STEP_BITS - k);
            if (rem >= trial) begin
               rem = rem - trial;
               quo[QUOT_BITS - 1 - s * STEP_BITS - k] = 1'b1;
            end
         end
         rem_in = rem;
         quo_in = quo;
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         den_ff[s] <= den_src;
         quo_ff[s] <= quo_in;
      end
   end

   assign quotient    = quo_ff[STAGES-1];
   assign rem_nonzero = |rem_ff[STAGES-1];

endmodule
`default_nettype wire

// File: tb/hsv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_checker: result checker for the rgb to hsv converter
// Watches the pixel and result channels and works out the hue, saturation
// and brightness of every pixel word taken. Each result word is compared,
// field by field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hsv_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire                busy,
   input  rhc_pkg::pixel_type req_data,
   input  wire                rsp_strobe,
   input  rhc_pkg::hsv_type   rsp_data,
   output int                 fail_count,
   output int                 pending,
   output int                 checked,
   output int                 grey_seen,
   output int                 wrap_seen,
   output int                 sector_seen [3]
);

   rhc_pkg::hsv_type hsv_expected [$];

   // floor division, rounding toward minus infinity
   function automatic int floor_quotient(int num, int den);
      if (num >= 0) begin
         return num / den;
      end
      return -((-num + den - 1) / den);
   endfunction

   // which channel holds the maximum, ties going red, then green, then blue
   function automatic rhc_pkg::sector_type sector_of(rhc_pkg::pixel_type px);
      if (px.red >= px.green && px.red >= px.blue) begin
         return rhc_pkg::SECTOR_RED;
      end else if (px.green >= px.blue) begin
         return rhc_pkg::SECTOR_GREEN;
      end
      return rhc_pkg::SECTOR_BLUE;
   endfunction

   // hue, saturation and brightness of one pixel
   function automatic rhc_pkg::hsv_type hsv_of_pixel(rhc_pkg::pixel_type px);
      int r, g, b;
      int top, bottom, chroma, num, hue;
      rhc_pkg::hsv_type res;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      top = (r > g) ? r : g;
      top = (top > b) ? top : b;
      bottom = (r < g) ? r : g;
      bottom = (bottom < b) ? bottom : b;
      chroma = top - bottom;
      res.brightness = rhc_pkg::BRIGHTNESS_BITS'(top);
      res.saturation = (top == 0) ? '0 :
                       rhc_pkg::SAT_BITS'((rhc_pkg::SAT_SCALE * chroma) / top);
      if (chroma == 0) begin
         hue = 0;
      end else begin
         case (sector_of(px))
            rhc_pkg::SECTOR_RED: begin
               hue = floor_quotient(rhc_pkg::HUE_SECTOR * (g - b), chroma);
               if (hue < 0) begin
                  hue += rhc_pkg::HUE_FULL;
               end
            end
            rhc_pkg::SECTOR_GREEN: begin
               num = 2 * rhc_pkg::HUE_SECTOR * chroma + rhc_pkg::HUE_SECTOR * (b - r);
               hue = floor_quotient(num, chroma);
            end
            default: begin
               num = 4 * rhc_pkg::HUE_SECTOR * chroma + rhc_pkg::HUE_SECTOR * (r - g);
               hue = floor_quotient(num, chroma);
            end
         endcase
      end
      res.hue = rhc_pkg::HUE_BITS'(hue);
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
      grey_seen = 0;
      wrap_seen = 0;
      sector_seen = '{0, 0, 0};
   end

   // record a prediction for every pixel word taken
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         hsv_expected.push_back(hsv_of_pixel(req_data));
         if (req_data.red == req_data.green && req_data.green == req_data.blue) begin
            grey_seen++;
         end else begin
            case (sector_of(req_data))
               rhc_pkg::SECTOR_RED: begin
                  sector_seen[0]++;
                  if (req_data.blue > req_data.green) begin
                     wrap_seen++;
                  end
               end
               rhc_pkg::SECTOR_GREEN: sector_seen[1]++;
               default:               sector_seen[2]++;
            endcase
         end
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin
      rhc_pkg::hsv_type want;
      if (!reset && rsp_strobe) begin
         if (hsv_expected.size() == 0) begin
            $display("%0t: unexpected result word hue=%0d sat=%0d bright=%0d",
                     $time, rsp_data.hue, rsp_data.saturation, rsp_data.brightness);
            fail_count++;
         end else begin
            want = hsv_expected.pop_front();
            checked++;
            if (rsp_data.hue !== want.hue) begin
               $display("%0t: hue mismatch, expected %0d, actual %0d",
                        $time, want.hue, rsp_data.hue);
               fail_count++;
            end
            if (rsp_data.saturation !== want.saturation) begin
               $display("%0t: saturation mismatch, expected %0d, actual %0d",
                        $time, want.saturation, rsp_data.saturation);
               fail_count++;
            end
            if (rsp_data.brightness !== want.brightness) begin
               $display("%0t: brightness mismatch, expected %0d, actual %0d",
                        $time, want.brightness, rsp_data.brightness);
               fail_count++;
            end
         end
      end
      pending <= hsv_expected.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the rgb to hsv converter
// Feeds directed corner pixels and then random pixel words, with random
// gaps between words, into the converter. A checker beside the block
// predicts every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_WORDS    = 1430;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PIXEL_WORD_BITS = $bits(rhc_pkg::pixel_type);

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   rhc_pkg::pixel_type req_data = '0;
   logic               busy;
   logic               rsp_strobe;
   rhc_pkg::hsv_type   rsp_data;

   int fail_count, pending, checked, grey_seen, wrap_seen;
   int sector_seen [3];
   int cycles = 0;
   int sent = 0;

   always #10 clock = ~clock;

   rgb_to_hsv_converter uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   hsv_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .grey_seen   (grey_seen),
      .wrap_seen   (wrap_seen),
      .sector_seen (sector_seen)
   );

   // run-away guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic rhc_pkg::pixel_type make_pixel(int r, int g, int b);
      rhc_pkg::pixel_type px;
      px.red = rhc_pkg::PIXEL_BITS'(r);
      px.green = rhc_pkg::PIXEL_BITS'(g);
      px.blue = rhc_pkg::PIXEL_BITS'(b);
      return px;
   endfunction

   function automatic int edge_value();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 1;
         2:       return 254;
         default: return 255;
      endcase
   endfunction

   // random pixel, weighted towards greys, ties, near-greys, edge values and wrap cases
   function automatic rhc_pkg::pixel_type random_pixel();
      int base, lo, hi;
      rhc_pkg::pixel_type px;
      case ($urandom_range(0, 9))
         4: begin
            base = $urandom_range(0, 255);
            px = make_pixel(base, base, base);
         end
         5: begin
            hi = $urandom_range(1, 255);
            lo = $urandom_range(0, hi);
            case ($urandom_range(0, 2))
               0:       px = make_pixel(hi, hi, lo);
               1:       px = make_pixel(lo, hi, hi);
               default: px = make_pixel(hi, lo, hi);
            endcase
         end
         6: begin
            base = $urandom_range(0, 251);
            px = make_pixel(base + $urandom_range(0, 4), base + $urandom_range(0, 4),
                            base + $urandom_range(0, 4));
         end
         7: px = make_pixel($urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 3));
         8: px = make_pixel(edge_value(), edge_value(), edge_value());
         9: begin
            // red largest with blue above green: hue wraps below 360 degrees
            hi = $urandom_range(2, 255);
            lo = $urandom_range(0, hi - 2);
            px = make_pixel(hi, lo, $urandom_range(lo + 1, hi));
         end
         default: px = PIXEL_WORD_BITS'($urandom());
      endcase
      return px;
   endfunction

   // offer one word after a gap and hold it until taken
   task automatic send_pixel(rhc_pkg::pixel_type px, int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
         req_data <= PIXEL_WORD_BITS'($urandom());
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   initial begin
      rhc_pkg::pixel_type corners [$];
      int gap;
      bit quiet;

      corners = {
         make_pixel(0, 0, 0),       make_pixel(255, 255, 255),
         make_pixel(128, 128, 128), make_pixel(1, 1, 1),
         make_pixel(255, 0, 0),     make_pixel(0, 255, 0),
         make_pixel(0, 0, 255),     make_pixel(255, 255, 0),
         make_pixel(0, 255, 255),   make_pixel(255, 0, 255),
         make_pixel(255, 0, 1),     make_pixel(255, 0, 254),
         make_pixel(1, 0, 0),       make_pixel(0, 0, 1),
         make_pixel(255, 1, 0),     make_pixel(0, 1, 255),
         make_pixel(254, 255, 0),   make_pixel(255, 254, 253),
         make_pixel(170, 85, 0),    make_pixel(0, 85, 170),
         make_pixel(200, 100, 150), make_pixel(1, 2, 3),
         make_pixel(85, 170, 255),  make_pixel(2, 1, 2)
      };

      // hold the synchronous reset, then release it on a falling clock edge
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed corners, back to back
      foreach (corners[i]) begin
         send_pixel(corners[i], 0);
      end

      // random words, with stretches of back-to-back traffic
      quiet = 1'b0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
         gap = quiet ? 0 : $urandom_range(0, 4);
         send_pixel(random_pixel(), gap);
      end
      @(negedge clock);
      start <= 1'b0;

      // drain the pipeline
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d pixel words sent, %0d results checked, %0d mismatches",
               sent, checked, fail_count);
      $display("sectors red/green/blue %0d/%0d/%0d, greys %0d, wrapped red hues %0d",
               sector_seen[0], sector_seen[1], sector_seen[2], grey_seen, wrap_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
